// File: sv/odet_pkg.sv
// ============================================================================
// odet_pkg - shared types and constants of the odometry distance tracker
// Field widths, saturation limits and the register map used by every file.
// ============================================================================
`default_nettype none

package odet_pkg;

    // Input and output field widths
    localparam int unsigned POS_W   = 32;
    localparam int unsigned THR_W   = 32;
    localparam int unsigned TOTAL_W = 48;
    localparam int unsigned REM_W   = 40;

    // Clamped difference magnitude is at most 2^30, so 31 bits
    localparam int unsigned MAG_W   = 31;
    // Square of a magnitude, and the sum of two squares, fit in 62 bits
    localparam int unsigned SQ_W    = 2 * MAG_W;
    // Floor root of a 62-bit value has 31 bits
    localparam int unsigned ROOT_W  = SQ_W / 2;
    // Root plus remainder
    localparam int unsigned SUM_W   = REM_W + 1;

    // Iteration counter covers MAG_W or ROOT_W steps
    localparam int unsigned CNT_W   = $clog2(MAG_W + 1);

    // Register map: byte address bits and register indexes
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic        REG_THRESHOLD = 1'b0;

    localparam logic [THR_W-1:0]   THRESHOLD_RESET = THR_W'(1024);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [REM_W-1:0]   REM_MAX   = {REM_W{1'b1}};

    typedef logic [MAG_W-1:0]   mag_t;
    typedef logic [SQ_W-1:0]    sq_t;
    typedef logic [ROOT_W-1:0]  root_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    // Handshake between the sequencer and a serial unit
    typedef struct packed {
        logic start;
        logic busy;
    } serial_ctl_t;

endpackage : odet_pkg

`default_nettype wire

// File: sv/odet_sqr.sv
// ============================================================================
// odet_sqr - bit-serial squarer
// Shift-and-add square of a 31-bit magnitude, one multiplier bit per cycle.
// ============================================================================
`default_nettype none

module odet_sqr (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire odet_pkg::mag_t mag,
    output logic               busy,
    output odet_pkg::sq_t      square
);
    import odet_pkg::*;

    sq_t  acc_reg,    acc_next;
    sq_t  mcand_reg,  mcand_next;
    mag_t mplier_reg, mplier_next;
    cnt_t cnt_reg,    cnt_next;
    logic busy_reg,   busy_next;

    // One partial product per cycle
    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        if (start)
        begin
            acc_next    = '0;
            mcand_next  = SQ_W'(mag);
            mplier_next = mag;
            cnt_next    = CNT_W'(MAG_W);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = {mcand_reg[SQ_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[MAG_W-1:1]};
            cnt_next    = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath, no reset
    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign busy   = busy_reg;
    assign square = acc_reg;

endmodule : odet_sqr

`default_nettype wire

// File: sv/odet_isqrt.sv
// ============================================================================
// odet_isqrt - bit-serial floor square root
// Restoring root of a 62-bit radicand, two radicand bits and one root bit
// per cycle.
// ============================================================================
`default_nettype none

module odet_isqrt (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire odet_pkg::sq_t   radicand,
    output logic                 busy,
    output odet_pkg::root_t      root
);
    import odet_pkg::*;

    // Partial remainder stays below 2^32; two more bits come in each step
    localparam int unsigned PR_W = ROOT_W + 3;

    sq_t             rad_reg,  rad_next;
    logic [PR_W-1:0] rem_reg,  rem_next;
    root_t           root_reg, root_next;
    cnt_t            cnt_reg,  cnt_next;
    logic            busy_reg, busy_next;

    logic [PR_W-1:0] shifted;
    logic [PR_W-1:0] trial;

    assign shifted = {rem_reg[PR_W-3:0], rad_reg[SQ_W-1 -: 2]};
    assign trial   = {1'b0, root_reg, 2'b01};

    // One root bit per cycle
    always_comb
    begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rad_next = {rad_reg[SQ_W-3:0], 2'b00};
            if (shifted >= trial)
            begin
                rem_next  = shifted - trial;
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted;
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule : odet_isqrt

`default_nettype wire

// File: sv/odometry_distance_event_tracker_top.sv
// Flow: an input transfer is taken in the idle state, then the difference, square,
//   root, sum and final update states run in that order; the final update writes
//   the output register once it is free. Input is stalled outside idle, so a new
//   sample waits for the last result; squarers and root are 31-step serial units.
// Reset: asynchronous, active low; clears the reference, remainder, total and
//   handshakes, and loads the threshold with 1024. No clearing pass.
// ============================================================================
// odometry_distance_event_tracker_top - distance event tracker
// Sequencer, state, threshold register and result register around the
// serial squarers and serial root.
// ============================================================================
`default_nettype none

module odometry_distance_event_tracker_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [odet_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [odet_pkg::PDATA_W-1:0]   pwdata,
    output logic      [odet_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    // input samples
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [odet_pkg::POS_W-1:0] pos_x,
    input  wire logic signed [odet_pkg::POS_W-1:0] pos_y,
    // results
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [odet_pkg::TOTAL_W-1:0]   travelled,
    output logic                                event_res
);
    import odet_pkg::*;

    localparam int unsigned D_W = POS_W + 1;
    localparam logic signed [D_W-1:0] DIFF_LIM = D_W'(1 << (MAG_W - 1));

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIFF,
        S_SQ,
        S_ROOT,
        S_SUM,
        S_FIN
    } state_t;

    // Clamp a difference to +/-2^30 and take its magnitude
    function automatic mag_t clamp_mag(input logic signed [D_W-1:0] d);
        logic signed [D_W-1:0] neg;
        neg = -d;
        if (d > DIFF_LIM || d < -DIFF_LIM)
            clamp_mag = MAG_W'(DIFF_LIM);
        else if (d[D_W-1])
            clamp_mag = neg[MAG_W-1:0];
        else
            clamp_mag = d[MAG_W-1:0];
    endfunction

    state_t               state_reg,   state_next;
    logic                 have_ref_reg, have_ref_next;
    logic [POS_W-1:0]     ref_x_reg,   ref_x_next;
    logic [POS_W-1:0]     ref_y_reg,   ref_y_next;
    logic [POS_W-1:0]     cur_x_reg,   cur_x_next;
    logic [POS_W-1:0]     cur_y_reg,   cur_y_next;
    logic [REM_W-1:0]     carry_reg,   carry_next;
    logic [TOTAL_W-1:0]   total_reg,   total_next;
    logic [SUM_W-1:0]     sum_reg,     sum_next;
    logic                 out_valid_reg, out_valid_next;
    logic [TOTAL_W-1:0]   travelled_reg, travelled_next;
    logic                 event_reg,   event_next;
    logic [THR_W-1:0]     thr_reg;

    serial_ctl_t          sqx_ctl, sqy_ctl, rt_ctl;
    sq_t                  sq_x, sq_y;
    root_t                root;
    mag_t                 mag_x, mag_y;

    logic                 in_fire;
    logic                 cfg_write;
    logic                 out_free;
    logic [TOTAL_W:0]     total_sum;
    logic [TOTAL_W-1:0]   total_sat;
    logic [SUM_W-1:0]     rem_raw;
    logic                 crossed;

    assign in_fire   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_write = psel && penable && pwrite && pready;

    // Differences against the reference
    assign mag_x = clamp_mag(D_W'($signed(cur_x_reg)) - D_W'($signed(ref_x_reg)));
    assign mag_y = clamp_mag(D_W'($signed(cur_y_reg)) - D_W'($signed(ref_y_reg)));

    assign sqx_ctl.start = (state_reg == S_DIFF);
    assign sqy_ctl.start = (state_reg == S_DIFF);
    assign rt_ctl.start  = (state_reg == S_SQ) && !sqx_ctl.busy && !sqy_ctl.busy;

    odet_sqr u_sqr_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sqx_ctl.start),
        .mag    (mag_x),
        .busy   (sqx_ctl.busy),
        .square (sq_x)
    );

    odet_sqr u_sqr_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (sqy_ctl.start),
        .mag    (mag_y),
        .busy   (sqy_ctl.busy),
        .square (sq_y)
    );

    odet_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rt_ctl.start),
        .radicand (sq_x + sq_y),
        .busy     (rt_ctl.busy),
        .root     (root)
    );

    // Total and remainder updates
    assign total_sum = {1'b0, total_reg} + (TOTAL_W + 1)'(sum_reg);
    assign total_sat = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    assign crossed   = (sum_reg > SUM_W'(thr_reg));
    assign rem_raw   = sum_reg - SUM_W'(thr_reg);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        have_ref_next  = have_ref_reg;
        ref_x_next     = ref_x_reg;
        ref_y_next     = ref_y_reg;
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        carry_next     = carry_reg;
        total_next     = total_reg;
        sum_next       = sum_reg;
        travelled_next = travelled_reg;
        event_next     = event_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cur_x_next = pos_x;
                    cur_y_next = pos_y;
                    if (!have_ref_reg)
                    begin
                        ref_x_next    = pos_x;
                        ref_y_next    = pos_y;
                        have_ref_next = 1'b1;
                    end
                    state_next = S_DIFF;
                end
            end
            S_DIFF:
                state_next = S_SQ;
            S_SQ:
            begin
                if (!sqx_ctl.busy && !sqy_ctl.busy)
                    state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (!rt_ctl.busy)
                begin
                    sum_next   = SUM_W'(root) + SUM_W'(carry_reg);
                    state_next = S_SUM;
                end
            end
            S_SUM:
                state_next = S_FIN;
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    travelled_next = total_sat;
                    event_next     = crossed;
                    if (crossed)
                    begin
                        total_next = total_sat;
                        carry_next = rem_raw[REM_W] ? REM_MAX : rem_raw[REM_W-1:0];
                        ref_x_next = cur_x_reg;
                        ref_y_next = cur_y_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            have_ref_reg  <= 1'b0;
            ref_x_reg     <= '0;
            ref_y_reg     <= '0;
            carry_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            have_ref_reg  <= have_ref_next;
            ref_x_reg     <= ref_x_next;
            ref_y_reg     <= ref_y_next;
            carry_reg     <= carry_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_x_reg     <= cur_x_next;
        cur_y_reg     <= cur_y_next;
        sum_reg       <= sum_next;
        travelled_reg <= travelled_next;
        event_reg     <= event_next;
    end

    // Threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= THRESHOLD_RESET;
        else if (cfg_write && paddr[2] == REG_THRESHOLD)
            thr_reg <= pwdata[THR_W-1:0];
    end

    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_THRESHOLD) ? PDATA_W'(thr_reg) : '0;
    assign out_valid = out_valid_reg;
    assign travelled = travelled_reg;
    assign event_res = event_reg;

    // Checks
    a_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg >= $past(total_reg))
        else $error("total distance decreased");

    a_event_total: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && event_reg) |-> (travelled_reg == total_reg))
        else $error("event result differs from total");

    a_root_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        rt_ctl.busy |-> (state_reg == S_ROOT))
        else $error("root unit busy outside root phase");

    a_ref_taken: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> have_ref_reg)
        else $error("reference not taken after first transfer");

endmodule : odometry_distance_event_tracker_top

`default_nettype wire
